// File: rtl/core/erm_pkg.sv
// ----------------------------------------------------------------------------
// erm_pkg
// Types and constants shared by the Euler-angle to rotation-matrix pipeline.
// ----------------------------------------------------------------------------
package erm_pkg;

  // one pose: binary angles, 65536 units per full turn
  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
  } erm_in_t;

  // nine matrix elements, signed Q1.14
  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } erm_out_t;

  localparam int CORDIC_ITERS = 16;
  // one register for range reduction, one per iteration, one for rounding
  localparam int CORDIC_LAT   = CORDIC_ITERS + 2;
  localparam int ZW           = 24;
  localparam int OUT_FRAC     = 14;
  localparam int OUT_MAX      = 16384;
  // reciprocal CORDIC gain times 2^32
  localparam logic [63:0] INV_GAIN32 = 64'd2608131496;

  // arctan(2^-i) in units of 2^-22 turn
  function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      4'd0:    v = 24'sd524288;
      4'd1:    v = 24'sd309505;
      4'd2:    v = 24'sd163534;
      4'd3:    v = 24'sd83012;
      4'd4:    v = 24'sd41667;
      4'd5:    v = 24'sd20854;
      4'd6:    v = 24'sd10430;
      4'd7:    v = 24'sd5215;
      4'd8:    v = 24'sd2608;
      4'd9:    v = 24'sd1304;
      4'd10:   v = 24'sd652;
      4'd11:   v = 24'sd326;
      4'd12:   v = 24'sd163;
      4'd13:   v = 24'sd81;
      4'd14:   v = 24'sd41;
      default: v = 24'sd20;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/euler_to_rotation_matrix.sv
// The CORDIC lanes feed the inner-product, outer-product, sum and rounded output registers.
// Throughput: one pose per cycle; busy is always low, set by the fully
// pipelined CORDIC lanes and multiplier stages.
// Reset (rst_n, synchronous, active low) clears only the valid pipeline;
// the receiver cannot stall, so each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Yaw, pitch and roll binary angles to the Z-Y-X rotation matrix in Q1.14 (yaw about Z, roll about Y, pitch about X).
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix import erm_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  erm_in_t  in_data,
  output logic     out_valid,
  output erm_out_t out_data
);

  localparam int CW  = FRAC_BITS + 2;
  localparam int PW  = 2 * CW;
  localparam int SW  = PW + 1;
  localparam int SH  = 2 * FRAC_BITS - OUT_FRAC;
  localparam int LAT = CORDIC_LAT + 4;
  localparam logic signed [PW-1:0] HALF_F = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] HALF_O = {{(SW-1){1'b0}}, 1'b1} << (SH - 1);
  localparam logic signed [SW-1:0] OMAX   = SW'(OUT_MAX);

  logic signed [CW-1:0] sy, cy, sp, cp, sr, cr;

  // stage A: inner products
  logic signed [CW-1:0] sy_r, cy_r, sp_r, cp_r, sr_r, cr_r, srsp_r, srcp_r;
  logic signed [PW-1:0] srsp_w, srcp_w;
  // stage B: products
  logic signed [PW-1:0] p_cycr_r, p_cysrsp_r, p_sycp_r, p_sysp_r, p_cysrcp_r;
  logic signed [PW-1:0] p_sycr_r, p_cycp_r, p_sysrsp_r, p_sysrcp_r, p_cysp_r;
  logic signed [PW-1:0] p_crsp_r, p_crcp_r;
  logic signed [SW-1:0] p_r20_r;
  // stage C: sums
  logic signed [SW-1:0] s_r [9];
  erm_out_t             out_r, out_nxt;
  logic [LAT-1:0]       vld_r, vld_nxt;

  function automatic logic signed [15:0] to_out(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = (v + HALF_O) >>> SH;
    if (t > OMAX)       t = OMAX;
    else if (t < -OMAX) t = -OMAX;
    return t[15:0];
  endfunction

  // sine/cosine lanes
  erm_cordic #(.FRAC_BITS(FRAC_BITS)) u_yaw (
    .clk(clk), .angle(in_data.yaw_angle), .sin_o(sy), .cos_o(cy));
  erm_cordic #(.FRAC_BITS(FRAC_BITS)) u_pitch (
    .clk(clk), .angle(in_data.pitch_angle), .sin_o(sp), .cos_o(cp));
  erm_cordic #(.FRAC_BITS(FRAC_BITS)) u_roll (
    .clk(clk), .angle(in_data.roll_angle), .sin_o(sr), .cos_o(cr));

  // inner products rounded back to FRAC_BITS
  assign srsp_w = (PW'(sr) * PW'(sp) + HALF_F) >>> FRAC_BITS;
  assign srcp_w = (PW'(sr) * PW'(cp) + HALF_F) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    sy_r <= sy; cy_r <= cy; sp_r <= sp; cp_r <= cp; sr_r <= sr; cr_r <= cr;
    srsp_r <= srsp_w[CW-1:0];
    srcp_r <= srcp_w[CW-1:0];
  end

  // outer products
  always_ff @(posedge clk) begin
    p_cycr_r   <= PW'(cy_r) * PW'(cr_r);
    p_cysrsp_r <= PW'(cy_r) * PW'(srsp_r);
    p_sycp_r   <= PW'(sy_r) * PW'(cp_r);
    p_sysp_r   <= PW'(sy_r) * PW'(sp_r);
    p_cysrcp_r <= PW'(cy_r) * PW'(srcp_r);
    p_sycr_r   <= PW'(sy_r) * PW'(cr_r);
    p_cycp_r   <= PW'(cy_r) * PW'(cp_r);
    p_sysrsp_r <= PW'(sy_r) * PW'(srsp_r);
    p_sysrcp_r <= PW'(sy_r) * PW'(srcp_r);
    p_cysp_r   <= PW'(cy_r) * PW'(sp_r);
    p_crsp_r   <= PW'(cr_r) * PW'(sp_r);
    p_crcp_r   <= PW'(cr_r) * PW'(cp_r);
    p_r20_r    <= -(SW'(sr_r) <<< FRAC_BITS);
  end

  // element sums at 2*FRAC_BITS fraction bits
  always_ff @(posedge clk) begin
    s_r[0] <= SW'(p_cycr_r);
    s_r[1] <= SW'(p_cysrsp_r) - SW'(p_sycp_r);
    s_r[2] <= SW'(p_sysp_r) + SW'(p_cysrcp_r);
    s_r[3] <= SW'(p_sycr_r);
    s_r[4] <= SW'(p_cycp_r) + SW'(p_sysrsp_r);
    s_r[5] <= SW'(p_sysrcp_r) - SW'(p_cysp_r);
    s_r[6] <= p_r20_r;
    s_r[7] <= SW'(p_crsp_r);
    s_r[8] <= SW'(p_crcp_r);
  end

  // round to Q1.14 and saturate
  always_comb begin
    out_nxt.r00 = to_out(s_r[0]);
    out_nxt.r01 = to_out(s_r[1]);
    out_nxt.r02 = to_out(s_r[2]);
    out_nxt.r10 = to_out(s_r[3]);
    out_nxt.r11 = to_out(s_r[4]);
    out_nxt.r12 = to_out(s_r[5]);
    out_nxt.r20 = to_out(s_r[6]);
    out_nxt.r21 = to_out(s_r[7]);
    out_nxt.r22 = to_out(s_r[8]);
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // valid bits follow each item down the pipe
  assign vld_nxt = {vld_r[LAT-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign busy      = 1'b0;
  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_r;

`ifndef SYNTH
  // every result strobe comes from an item that start brought into the pipe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result strobe without matching item");

  // saturation keeps elements within one
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.r00 <= 16'sd16384 && out_data.r00 >= -16'sd16384 &&
                   out_data.r11 <= 16'sd16384 && out_data.r11 >= -16'sd16384))
    else $error("matrix element out of range");

  // a roll-only element is never the most negative code
  a_r20: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.r20 != 16'sh8000)
    else $error("r20 saturation failed");
`endif

endmodule

// File: rtl/core/erm_cordic.sv
// ----------------------------------------------------------------------------
// erm_cordic
// Pipelined rotation-mode CORDIC: sine and cosine of one binary angle,
// one iteration per stage, rounded and clamped to FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module erm_cordic import erm_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                         clk,
  input  logic signed [15:0]           angle,
  output logic signed [FRAC_BITS+1:0]  sin_o,
  output logic signed [FRAC_BITS+1:0]  cos_o
);

  localparam int IFB = FRAC_BITS + 2;
  localparam int XW  = IFB + 3;
  localparam int CW  = FRAC_BITS + 2;
  localparam logic [63:0] X0_U = (INV_GAIN32 * 64'd2 + 64'd1) >> (33 - IFB);
  localparam logic signed [XW-1:0] X0  = X0_U[XW-1:0];
  localparam logic signed [XW-1:0] TWO = {{(XW-2){1'b0}}, 2'b10};
  localparam logic signed [XW-1:0] LIM = {{(XW-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic signed [XW-1:0] x_r [CORDIC_ITERS+1];
  logic signed [XW-1:0] y_r [CORDIC_ITERS+1];
  logic signed [ZW-1:0] z_r [CORDIC_ITERS+1];
  logic                 neg_r [CORDIC_ITERS+1];

  logic signed [16:0]   red_a;
  logic                 red_neg;
  logic signed [XW-1:0] xs, ys, xc, yc;
  logic signed [CW-1:0] cos_nxt, sin_nxt;
  logic signed [CW-1:0] cos_r, sin_r;

  // fold into the right half plane, remember the sign flip
  always_comb begin
    red_a   = 17'(angle);
    red_neg = 1'b0;
    if (red_a > 17'sd16384) begin
      red_a   = red_a - 17'sd32768;
      red_neg = 1'b1;
    end else if (red_a < -17'sd16384) begin
      red_a   = red_a + 17'sd32768;
      red_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= X0;
    y_r[0]   <= '0;
    z_r[0]   <= ZW'(red_a) <<< 6;
    neg_r[0] <= red_neg;
  end

  // micro-rotation stages
  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (!z_r[i][ZW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_lut(4'(i));
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_lut(4'(i));
      end
      neg_r[i+1] <= neg_r[i];
    end
  end

  // drop the two guard bits, clamp, undo the half-turn fold
  always_comb begin
    xs = (x_r[CORDIC_ITERS] + TWO) >>> 2;
    ys = (y_r[CORDIC_ITERS] + TWO) >>> 2;
    xc = (xs > LIM) ? LIM : ((xs < -LIM) ? -LIM : xs);
    yc = (ys > LIM) ? LIM : ((ys < -LIM) ? -LIM : ys);
    if (neg_r[CORDIC_ITERS]) begin
      xc = -xc;
      yc = -yc;
    end
    cos_nxt = xc[CW-1:0];
    sin_nxt = yc[CW-1:0];
  end

  always_ff @(posedge clk) begin
    cos_r <= cos_nxt;
    sin_r <= sin_nxt;
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives poses into the Euler-angle to rotation-matrix pipeline in random
// bursts, predicts each matrix with a bit-exact CORDIC model and compares
// every element of every result in order.
// ----------------------------------------------------------------------------
module testbench;
  import erm_pkg::*;

  localparam int FB        = 14;
  localparam int LIMIT_CYC = 400000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  erm_in_t  in_data = '0;
  logic     out_valid;
  erm_out_t out_data;

  erm_in_t  pose_q[$];
  erm_out_t matrix_q[$];
  int       errors = 0;
  int       cycles = 0;
  bit       feeding_done = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;

  euler_to_rotation_matrix #(.FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // floor shift for signed values
  function automatic longint sra(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // sine and cosine of a binary angle, FB fractional bits
  task automatic sin_cos(input logic signed [15:0] ang, output longint s, output longint c);
    longint a, x, y, z, dx, dy;
    bit flip;
    a = ang;
    flip = 1'b0;
    if (a > 16384) begin
      a -= 32768; flip = 1'b1;
    end else if (a < -16384) begin
      a += 32768; flip = 1'b1;
    end
    x = longint'((INV_GAIN32 * 2 + 1) >> (33 - (FB + 2)));
    y = 0;
    z = a * 64;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = sra(y, i);
      dy = sra(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_lut(i[3:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_lut(i[3:0]));
      end
    end
    x = clip(sra(x + 2, 2), longint'(1) << FB);
    y = clip(sra(y + 2, 2), longint'(1) << FB);
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic longint mul_round(longint a, longint b);
    return sra(a * b + (longint'(1) << (FB - 1)), FB);
  endfunction

  function automatic logic signed [15:0] to_q14(longint v);
    int sh;
    sh = 2 * FB - OUT_FRAC;
    return 16'(clip(sra(v + (longint'(1) << (sh - 1)), sh), OUT_MAX));
  endfunction

  task automatic predict_matrix(input erm_in_t p, output erm_out_t m);
    longint sy, cy, sp, cp, sr, cr, srsp, srcp;
    sin_cos(p.yaw_angle, sy, cy);
    sin_cos(p.pitch_angle, sp, cp);
    sin_cos(p.roll_angle, sr, cr);
    srsp = mul_round(sr, sp);
    srcp = mul_round(sr, cp);
    m.r00 = to_q14(cy * cr);
    m.r01 = to_q14(cy * srsp - sy * cp);
    m.r02 = to_q14(sy * sp + cy * srcp);
    m.r10 = to_q14(sy * cr);
    m.r11 = to_q14(cy * cp + sy * srsp);
    m.r12 = to_q14(sy * srcp - cy * sp);
    m.r20 = to_q14(-(sr * (longint'(1) << FB)));
    m.r21 = to_q14(cr * sp);
    m.r22 = to_q14(cr * cp);
  endtask

  function automatic logic signed [15:0] pick_angle();
    logic signed [15:0] edges [10] = '{-32768, 32767, 0, 16384, -16384, 16385, -16385,
                                       8192, -8192, 1};
    if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 9)];
    return 16'($urandom);
  endfunction

  // stimulus: directed corners, then random poses
  initial begin
    logic signed [15:0] corner [9] = '{-32768, 32767, 0, 1, -1, 16384, -16384, 16385, -16385};
    erm_in_t p;
    for (int i = 0; i < 9; i++) begin
      p.yaw_angle = corner[i];
      p.pitch_angle = corner[(i + 3) % 9];
      p.roll_angle = corner[(i + 6) % 9];
      pose_q.insert(pose_q.size(), p);
    end
    p = '{16'sh5555, 16'shAAAA, 16'sh7FFF};
    pose_q.insert(pose_q.size(), p);
    p = '{16'shAAAA, 16'sh5555, -16'sh8000};
    pose_q.insert(pose_q.size(), p);
    for (int i = 0; i < 2000; i++) begin
      p.yaw_angle = pick_angle();
      p.pitch_angle = pick_angle();
      p.roll_angle = pick_angle();
      pose_q.insert(pose_q.size(), p);
    end
    feeding_done = 1'b1;
  end

  // reset, then cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 3) rst_n <= 1'b1;
    if (cycles > LIMIT_CYC) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    erm_in_t  p;
    erm_out_t m;
    if (rst_n && start && !busy) begin
      predict_matrix(in_data, m);
      matrix_q.insert(matrix_q.size(), m);
    end
    if (!rst_n || cycles < 5) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold current item until accepted
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pose_q.size() > 0) begin
      p = pose_q.pop_front();
      in_data <= p;
      start <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    erm_out_t want;
    if (rst_n && out_valid) begin
      if (matrix_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = matrix_q.pop_front();
        if (want.r00 !== out_data.r00) begin
          $display("%0t: r00 exp %0d got %0d", $time, want.r00, out_data.r00); errors++;
        end
        if (want.r01 !== out_data.r01) begin
          $display("%0t: r01 exp %0d got %0d", $time, want.r01, out_data.r01); errors++;
        end
        if (want.r02 !== out_data.r02) begin
          $display("%0t: r02 exp %0d got %0d", $time, want.r02, out_data.r02); errors++;
        end
        if (want.r10 !== out_data.r10) begin
          $display("%0t: r10 exp %0d got %0d", $time, want.r10, out_data.r10); errors++;
        end
        if (want.r11 !== out_data.r11) begin
          $display("%0t: r11 exp %0d got %0d", $time, want.r11, out_data.r11); errors++;
        end
        if (want.r12 !== out_data.r12) begin
          $display("%0t: r12 exp %0d got %0d", $time, want.r12, out_data.r12); errors++;
        end
        if (want.r20 !== out_data.r20) begin
          $display("%0t: r20 exp %0d got %0d", $time, want.r20, out_data.r20); errors++;
        end
        if (want.r21 !== out_data.r21) begin
          $display("%0t: r21 exp %0d got %0d", $time, want.r21, out_data.r21); errors++;
        end
        if (want.r22 !== out_data.r22) begin
          $display("%0t: r22 exp %0d got %0d", $time, want.r22, out_data.r22); errors++;
        end
      end
    end
  end

  // end of run: drain, then a tail at least as long as the pipeline
  initial begin
    wait (feeding_done && rst_n);
    wait (pose_q.size() == 0 && !start && matrix_q.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && matrix_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
